>>> design/twbc_pkg.sv
package twbc_pkg;

	localparam int SIGNAL_WIDTH       = 32;
	localparam int GAIN_FRACTION_BITS = 24;

	localparam int FIELD_W    = 32;
	localparam int NUM_IN     = 7;
	localparam int IN_W       = NUM_IN * FIELD_W;
	localparam int DRIVE_W    = 24;
	localparam int OUT_W      = 2 * DRIVE_W;
	localparam int GAIN_W     = 32;
	localparam int FC_W       = 25;
	localparam int TC_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int AW         = SIGNAL_WIDTH + 8;
	localparam int PROD_W     = SIGNAL_WIDTH + GAIN_W;
	localparam int NUM_STEPS  = 46;
	localparam int STEP_W     = $clog2(NUM_STEPS);

	typedef logic signed [AW-1:0]     acc_t;
	typedef logic signed [GAIN_W-1:0] gain_val_t;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_KP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN    = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_KP      = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_KD      = CFG_IDX_W'(7);

	localparam logic [FC_W-1:0] FC_RESET  = FC_W'(15938355);
	localparam gain_val_t PKP_RESET  = GAIN_W'(167772160);
	localparam gain_val_t SKP_RESET  = GAIN_W'(251658);
	localparam gain_val_t SKI_RESET  = GAIN_W'(84);
	localparam gain_val_t ANG_RESET  = GAIN_W'(2013265920);
	localparam gain_val_t RATE_RESET = GAIN_W'(33554432);
	localparam gain_val_t TKP_RESET  = GAIN_W'(-167772160);
	localparam gain_val_t TKD_RESET  = GAIN_W'(-16777216);

	localparam gain_val_t GAIN_ONE  = GAIN_W'(longint'(1) << GAIN_FRACTION_BITS);
	localparam gain_val_t TURN_SPAN = GAIN_W'(411566);
	localparam gain_val_t POS_STEP  = GAIN_W'(16777);

	localparam acc_t YAW_OFFSET = AW'(205887);
	localparam acc_t WRAP_LIMIT = AW'(205783);
	localparam acc_t TURN_BASE  = AW'(205783);

	localparam acc_t SIG_HI = acc_t'((longint'(1) <<< (SIGNAL_WIDTH - 1)) - longint'(1));
	localparam acc_t SIG_LO = acc_t'(-(longint'(1) <<< (SIGNAL_WIDTH - 1)));
	localparam acc_t ACC_HI = {1'b0, {(AW - 1){1'b1}}};
	localparam acc_t ACC_LO = {1'b1, {(AW - 1){1'b0}}};
	localparam acc_t TC_HI  = AW'(32767);
	localparam acc_t TC_LO  = AW'(-32768);
	localparam acc_t POS_HI = AW'(983040);
	localparam acc_t SPI_HI = AW'(13107);
	localparam acc_t SPD_HI = AW'(32768);
	localparam acc_t DRV_HI = AW'(6553600);

	typedef enum logic [1:0] {K_NOP, K_ALU, K_MUL, K_WRM} kind_t;

	typedef enum logic [4:0] {
		S_ZERO, S_RIGHT, S_LEFT, S_YAW, S_PITCH, S_RATE, S_TARGET, S_STEP,
		S_PYAW, S_TC, S_FS, S_PSUM, S_SI, S_PTE, S_YT,
		S_T0, S_T1, S_T2, S_T3, S_YOFF, S_TBASE, S_DELTA
	} src_t;

	typedef enum logic [1:0] {B_ADD, B_SUB, B_ADD2, B_SUB2} bmode_t;

	typedef enum logic [2:0] {C_NONE, C_SIG, C_TC, C_POS, C_SPI, C_SPD, C_DRV} bound_t;

	typedef enum logic [3:0] {
		D_TC, D_PYAW, D_FS, D_PSUM, D_SI, D_PTE, D_YT, D_T0, D_T1, D_T2, D_T3
	} dst_t;

	typedef enum logic [3:0] {
		G_FCNEW, G_FC, G_PSTEP, G_PKP, G_SKP, G_SKI, G_ANG, G_RATE, G_TKP, G_TKD, G_SPAN
	} gain_t;

	typedef struct packed {
		kind_t  kind;
		src_t   a;
		logic   neg_a;
		src_t   b;
		bmode_t bmode;
		bound_t bound;
		dst_t   dst;
		gain_t  gain;
	} uop_t;

	function automatic uop_t op_alu(dst_t d_i, src_t a_i, logic na_i, src_t b_i,
			bmode_t m_i, bound_t c_i);
		uop_t u;
		u = '{kind: K_ALU, a: a_i, neg_a: na_i, b: b_i, bmode: m_i, bound: c_i,
			dst: d_i, gain: G_FC};
		return u;
	endfunction

	function automatic uop_t op_mul(src_t a_i, gain_t g_i);
		uop_t u;
		u = '{kind: K_MUL, a: a_i, neg_a: 1'b0, b: S_ZERO, bmode: B_ADD, bound: C_NONE,
			dst: D_T0, gain: g_i};
		return u;
	endfunction

	function automatic uop_t op_wrm(dst_t d_i);
		uop_t u;
		u = '{kind: K_WRM, a: S_ZERO, neg_a: 1'b0, b: S_ZERO, bmode: B_ADD, bound: C_NONE,
			dst: d_i, gain: G_FC};
		return u;
	endfunction

	function automatic uop_t op_nop();
		uop_t u;
		u = '{kind: K_NOP, a: S_ZERO, neg_a: 1'b0, b: S_ZERO, bmode: B_ADD, bound: C_NONE,
			dst: D_T0, gain: G_FC};
		return u;
	endfunction

	function automatic uop_t ucode(logic [STEP_W-1:0] idx);
		uop_t u;
		unique case (idx)
			// yaw unwrap
			STEP_W'(0):  u = op_alu(D_T0, S_YAW, 1'b0, S_YOFF, B_ADD, C_SIG);
			STEP_W'(1):  u = op_alu(D_T1, S_T0, 1'b0, S_PYAW, B_SUB, C_NONE);
			STEP_W'(2):  u = op_alu(D_TC, S_TC, 1'b0, S_DELTA, B_ADD, C_TC);
			STEP_W'(3):  u = op_alu(D_PYAW, S_T0, 1'b0, S_ZERO, B_ADD, C_NONE);
			STEP_W'(4):  u = op_mul(S_TC, G_SPAN);
			STEP_W'(5):  u = op_wrm(D_T2);
			STEP_W'(6):  u = op_alu(D_T2, S_T2, 1'b0, S_T0, B_ADD, C_SIG);
			// speed filter and position
			STEP_W'(7):  u = op_alu(D_T0, S_RIGHT, 1'b1, S_LEFT, B_SUB, C_SIG);
			STEP_W'(8):  u = op_mul(S_T0, G_FCNEW);
			STEP_W'(9):  u = op_wrm(D_T1);
			STEP_W'(10): u = op_mul(S_FS, G_FC);
			STEP_W'(11): u = op_wrm(D_T3);
			STEP_W'(12): u = op_alu(D_FS, S_T1, 1'b0, S_T3, B_ADD, C_SIG);
			STEP_W'(13): u = op_mul(S_FS, G_PSTEP);
			STEP_W'(14): u = op_wrm(D_T0);
			STEP_W'(15): u = op_alu(D_PSUM, S_PSUM, 1'b0, S_T0, B_ADD, C_SIG);
			// position loop
			STEP_W'(16): u = op_alu(D_T0, S_TARGET, 1'b0, S_PSUM, B_SUB, C_SIG);
			STEP_W'(17): u = op_mul(S_T0, G_PKP);
			STEP_W'(18): u = op_wrm(D_T0);
			STEP_W'(19): u = op_alu(D_T0, S_T0, 1'b0, S_ZERO, B_ADD, C_POS);
			// speed loop
			STEP_W'(20): u = op_alu(D_T0, S_T0, 1'b0, S_FS, B_SUB, C_SIG);
			STEP_W'(21): u = op_mul(S_T0, G_SKI);
			STEP_W'(22): u = op_wrm(D_T1);
			STEP_W'(23): u = op_alu(D_SI, S_SI, 1'b0, S_T1, B_ADD, C_SPI);
			STEP_W'(24): u = op_mul(S_T0, G_SKP);
			STEP_W'(25): u = op_wrm(D_T1);
			STEP_W'(26): u = op_alu(D_T1, S_T1, 1'b0, S_SI, B_ADD, C_SPD);
			// balance law
			STEP_W'(27): u = op_alu(D_T1, S_PITCH, 1'b0, S_T1, B_SUB, C_SIG);
			STEP_W'(28): u = op_mul(S_T1, G_ANG);
			STEP_W'(29): u = op_wrm(D_T1);
			STEP_W'(30): u = op_alu(D_T1, S_T1, 1'b1, S_ZERO, B_ADD, C_SIG);
			STEP_W'(31): u = op_mul(S_RATE, G_RATE);
			STEP_W'(32): u = op_wrm(D_T3);
			STEP_W'(33): u = op_alu(D_T1, S_T1, 1'b0, S_T3, B_SUB, C_SIG);
			// turn loop
			STEP_W'(34): u = op_alu(D_YT, S_YT, 1'b0, S_STEP, B_ADD, C_SIG);
			STEP_W'(35): u = op_alu(D_T3, S_TBASE, 1'b0, S_YT, B_ADD2, C_SIG);
			STEP_W'(36): u = op_alu(D_T3, S_T3, 1'b0, S_T2, B_SUB, C_SIG);
			STEP_W'(37): u = op_alu(D_T0, S_T3, 1'b0, S_PTE, B_SUB, C_SIG);
			STEP_W'(38): u = op_mul(S_T3, G_TKP);
			STEP_W'(39): u = op_wrm(D_T2);
			STEP_W'(40): u = op_mul(S_T0, G_TKD);
			STEP_W'(41): u = op_wrm(D_T0);
			STEP_W'(42): u = op_alu(D_PTE, S_T3, 1'b0, S_ZERO, B_ADD, C_NONE);
			STEP_W'(43): u = op_alu(D_T0, S_T2, 1'b0, S_T0, B_ADD, C_DRV);
			// mix
			STEP_W'(44): u = op_alu(D_T2, S_T1, 1'b0, S_T0, B_ADD, C_DRV);
			STEP_W'(45): u = op_alu(D_T3, S_T1, 1'b0, S_T0, B_SUB2, C_DRV);
			default:     u = op_nop();
		endcase
		return u;
	endfunction

endpackage

>>> design/two_wheel_balance_controller_core.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   speeds, yaw, pitch, rate, target, step
// m_axis    out        m_axis_tvalid/m_axis_tready   right_drive, left_drive
// cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// One item takes 46 micro-steps on the shared multiplier and adder/clamp unit; the result is
// then loaded into the output register once that register is free or being taken.
// s_axis_tready is high only while idle; the next item is accepted as soon as the result
// sits in the output register. A stalled m_axis holds the finished result in the sequencer.
// Reset clears the controller state and loads the default gains.
module two_wheel_balance_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [twbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [twbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// right_speed, left_speed, yaw_angle, pitch_angle, pitch_rate, position_target, turn_step
	input  logic [twbc_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// right_drive, left_drive
	output logic [twbc_pkg::OUT_W-1:0]       m_axis_tdata
);
	import twbc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef logic signed [SIGNAL_WIDTH-1:0] sig_t;
	typedef logic signed [FIELD_W-1:0]      field_t;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;

	logic [FC_W-1:0] fc_q;
	gain_val_t       pkp_q, skp_q, ski_q, ang_q, rate_gain_q, tkp_q, tkd_q;

	sig_t                   pyaw_q, fs_q, psum_q, si_q, pte_q, yt_q;
	logic signed [TC_W-1:0] tc_q;
	acc_t                   t0_q, t1_q, t2_q, t3_q;

	field_t right_q, left_q, yaw_q, pitch_q, rate_q, target_q, step_in_q;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     raw_s1;

	uop_t                     u;
	logic                     accept;
	logic                     run;
	logic                     last_step;
	logic                     out_load;
	logic                     wb_en;
	acc_t                     delta;
	acc_t                     opa, opb, sum, lo, hi, alu_res, mul_res, wb;
	acc_t                     mul_src;
	logic signed [SIGNAL_WIDTH-1:0] mul_a;
	gain_val_t                mul_g;
	gain_val_t                fc_new;
	logic signed [PROD_W-1:0] prod_rnd, prod_sh;

	function automatic acc_t pick(src_t s);
		acc_t v;
		case (s)
			S_ZERO:   v = '0;
			S_RIGHT:  v = acc_t'(right_q);
			S_LEFT:   v = acc_t'(left_q);
			S_YAW:    v = acc_t'(yaw_q);
			S_PITCH:  v = acc_t'(pitch_q);
			S_RATE:   v = acc_t'(rate_q);
			S_TARGET: v = acc_t'(target_q);
			S_STEP:   v = acc_t'(step_in_q);
			S_PYAW:   v = acc_t'(pyaw_q);
			S_TC:     v = acc_t'(tc_q);
			S_FS:     v = acc_t'(fs_q);
			S_PSUM:   v = acc_t'(psum_q);
			S_SI:     v = acc_t'(si_q);
			S_PTE:    v = acc_t'(pte_q);
			S_YT:     v = acc_t'(yt_q);
			S_T0:     v = t0_q;
			S_T1:     v = t1_q;
			S_T2:     v = t2_q;
			S_T3:     v = t3_q;
			S_YOFF:   v = YAW_OFFSET;
			S_TBASE:  v = TURN_BASE;
			S_DELTA:  v = delta;
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign accept        = (state_q == ST_IDLE) && s_axis_tvalid;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign run           = (state_q == ST_RUN);
	assign last_step     = (step_q == STEP_W'(NUM_STEPS - 1));
	assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign u             = ucode(step_q);
	assign wb_en         = run && (u.kind == K_ALU || u.kind == K_WRM);

	always_comb begin
		if (t1_q > WRAP_LIMIT) begin
			delta = -acc_t'(1);
		end else if (t1_q < -WRAP_LIMIT) begin
			delta = acc_t'(1);
		end else begin
			delta = '0;
		end
	end

	always_comb begin
		opa = pick(u.a);
		if (u.neg_a) begin
			opa = -opa;
		end
		opb = pick(u.b);
		case (u.bmode)
			B_ADD:   sum = opa + opb;
			B_SUB:   sum = opa - opb;
			B_ADD2:  sum = opa + (opb <<< 1);
			B_SUB2:  sum = opa - (opb <<< 1);
			default: sum = opa;
		endcase
		case (u.bound)
			C_SIG:   begin lo = SIG_LO;  hi = SIG_HI; end
			C_TC:    begin lo = TC_LO;   hi = TC_HI; end
			C_POS:   begin lo = -POS_HI; hi = POS_HI; end
			C_SPI:   begin lo = -SPI_HI; hi = SPI_HI; end
			C_SPD:   begin lo = -SPD_HI; hi = SPD_HI; end
			C_DRV:   begin lo = -DRV_HI; hi = DRV_HI; end
			default: begin lo = ACC_LO;  hi = ACC_HI; end
		endcase
		if (sum < lo) begin
			alu_res = lo;
		end else if (sum > hi) begin
			alu_res = hi;
		end else begin
			alu_res = sum;
		end
	end

	assign fc_new = GAIN_ONE - gain_val_t'(fc_q);

	always_comb begin
		mul_src = pick(u.a);
		mul_a   = mul_src[SIGNAL_WIDTH-1:0];
		case (u.gain)
			G_FCNEW: mul_g = fc_new;
			G_FC:    mul_g = gain_val_t'(fc_q);
			G_PSTEP: mul_g = POS_STEP;
			G_PKP:   mul_g = pkp_q;
			G_SKP:   mul_g = skp_q;
			G_SKI:   mul_g = ski_q;
			G_ANG:   mul_g = ang_q;
			G_RATE:  mul_g = rate_gain_q;
			G_TKP:   mul_g = tkp_q;
			G_TKD:   mul_g = tkd_q;
			G_SPAN:  mul_g = TURN_SPAN;
			default: mul_g = '0;
		endcase
	end

	// truncate toward zero, then saturate to the signal range; a G_SPAN product is passed on unscaled
	always_comb begin
		prod_rnd = prod_s1;
		if (prod_s1 < 0) begin
			prod_rnd = prod_s1 + PROD_W'((longint'(1) << GAIN_FRACTION_BITS) - longint'(1));
		end
		prod_sh = prod_rnd >>> GAIN_FRACTION_BITS;
		if (raw_s1) begin
			mul_res = prod_s1[AW-1:0];
		end else if (prod_sh > PROD_W'(SIG_HI)) begin
			mul_res = SIG_HI;
		end else if (prod_sh < PROD_W'(SIG_LO)) begin
			mul_res = SIG_LO;
		end else begin
			mul_res = prod_sh[AW-1:0];
		end
	end

	assign wb = (u.kind == K_WRM) ? mul_res : alu_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= FC_RESET;
			pkp_q       <= PKP_RESET;
			skp_q       <= SKP_RESET;
			ski_q       <= SKI_RESET;
			ang_q       <= ANG_RESET;
			rate_gain_q <= RATE_RESET;
			tkp_q       <= TKP_RESET;
			tkd_q       <= TKD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_COEFF: fc_q        <= cfg_data[FC_W-1:0];
				REG_POSITION_KP:  pkp_q       <= cfg_data[GAIN_W-1:0];
				REG_SPEED_KP:     skp_q       <= cfg_data[GAIN_W-1:0];
				REG_SPEED_KI:     ski_q       <= cfg_data[GAIN_W-1:0];
				REG_ANGLE_GAIN:   ang_q       <= cfg_data[GAIN_W-1:0];
				REG_RATE_GAIN:    rate_gain_q <= cfg_data[GAIN_W-1:0];
				REG_TURN_KP:      tkp_q       <= cfg_data[GAIN_W-1:0];
				REG_TURN_KD:      tkd_q       <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pyaw_q <= '0;
			tc_q   <= '0;
			fs_q   <= '0;
			psum_q <= '0;
			si_q   <= '0;
			pte_q  <= '0;
			yt_q   <= '0;
		end else if (wb_en) begin
			case (u.dst)
				D_TC:    tc_q   <= wb[TC_W-1:0];
				D_PYAW:  pyaw_q <= wb[SIGNAL_WIDTH-1:0];
				D_FS:    fs_q   <= wb[SIGNAL_WIDTH-1:0];
				D_PSUM:  psum_q <= wb[SIGNAL_WIDTH-1:0];
				D_SI:    si_q   <= wb[SIGNAL_WIDTH-1:0];
				D_PTE:   pte_q  <= wb[SIGNAL_WIDTH-1:0];
				D_YT:    yt_q   <= wb[SIGNAL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			right_q   <= s_axis_tdata[0*FIELD_W +: FIELD_W];
			left_q    <= s_axis_tdata[1*FIELD_W +: FIELD_W];
			yaw_q     <= s_axis_tdata[2*FIELD_W +: FIELD_W];
			pitch_q   <= s_axis_tdata[3*FIELD_W +: FIELD_W];
			rate_q    <= s_axis_tdata[4*FIELD_W +: FIELD_W];
			target_q  <= s_axis_tdata[5*FIELD_W +: FIELD_W];
			step_in_q <= s_axis_tdata[6*FIELD_W +: FIELD_W];
		end
		if (run && u.kind == K_MUL) begin
			prod_s1 <= mul_a * mul_g;
			raw_s1  <= (u.gain == G_SPAN);
		end
		if (wb_en) begin
			case (u.dst)
				D_T0:    t0_q <= wb;
				D_T1:    t1_q <= wb;
				D_T2:    t2_q <= wb;
				D_T3:    t3_q <= wb;
				default: ;
			endcase
		end
		if (out_load) begin
			m_data_q <= {t3_q[DRIVE_W-1:0], t2_q[DRIVE_W-1:0]};
		end
	end

endmodule

>>> tb/tb_two_wheel_balance_controller_core.sv
`timescale 1ns / 1ps

module tb_two_wheel_balance_controller_core;
	import twbc_pkg::*;

	localparam longint SAT_HI = (longint'(1) <<< (SIGNAL_WIDTH - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam longint UNITY = longint'(1) <<< GAIN_FRACTION_BITS;
	localparam longint YAW_BIAS = 205887;
	localparam longint REV_SPAN = 411566;
	localparam longint HALF_TURN = 205783;
	localparam longint TURN_ORIGIN = 205783;
	localparam longint TRAVEL_SCALE = 16777;
	localparam int TRAVEL_SHIFT = 24;
	localparam longint POS_LIMIT = 983040;
	localparam longint INTEG_LIMIT = 13107;
	localparam longint SPEED_LIMIT = 32768;
	localparam longint DRIVE_LIMIT = 6553600;
	localparam longint REV_MAX = 32767;
	localparam longint REV_MIN = -32768;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 175;
	localparam int NO_GAP_PHASE = 6;
	localparam int QUIET_LIMIT = 4000;

	typedef logic signed [FIELD_W-1:0] word_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

	localparam word_t WMAX = 32'sh7FFF_FFFF;
	localparam word_t WMIN = 32'sh8000_0000;

	typedef struct {
		word_t right_speed;
		word_t left_speed;
		word_t yaw_angle;
		word_t pitch_angle;
		word_t pitch_rate;
		word_t position_target;
		word_t turn_step;
	} tick_in_t;

	typedef struct {
		drive_t right_drive;
		drive_t left_drive;
	} tick_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	two_wheel_balance_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	longint ctrl_reg [8];
	longint reset_reg [8];
	longint last_yaw, rev_count, speed_lp, travel, speed_acc, last_turn_err, heading_goal;
	longint yaw_walk;

	tick_in_t tick_q [$];
	tick_out_t drive_q [$];
	tick_in_t held_tick;
	tick_out_t want;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	bit gaps_on = 1'b1;

	function automatic longint sat_sig(longint x);
		return x < SAT_LO ? SAT_LO : (x > SAT_HI ? SAT_HI : x);
	endfunction

	function automatic longint clip(longint x, longint lim);
		return x < -lim ? -lim : (x > lim ? lim : x);
	endfunction

	// magnitude product, truncated toward zero, saturated to the signal width
	function automatic longint scaled_mul(longint a, longint g, int sh);
		logic neg;
		longint q;
		longint lim;
		neg = (a < 0) != (g < 0);
		q = ((a < 0 ? -a : a) * (g < 0 ? -g : g)) >>> sh;
		lim = neg ? SAT_HI + 1 : SAT_HI;
		if (q > lim)
			q = lim;
		return neg ? -q : q;
	endfunction

	function automatic longint gain_mul(longint a, longint g);
		return scaled_mul(a, g, GAIN_FRACTION_BITS);
	endfunction

	function automatic tick_out_t controller_tick(tick_in_t t);
		longint y, delta, yaw_sum, err, pos_cmd, spd_err, spd_cmd, bal;
		longint setp, terr, turn, r, l;
		tick_out_t o;
		y = sat_sig(longint'(t.yaw_angle) + YAW_BIAS);
		delta = y - last_yaw;
		if (delta > HALF_TURN) begin
			if (rev_count > REV_MIN)
				rev_count = rev_count - 1;
		end else if (delta < -HALF_TURN) begin
			if (rev_count < REV_MAX)
				rev_count = rev_count + 1;
		end
		yaw_sum = sat_sig(REV_SPAN * rev_count + y);
		last_yaw = y;

		err = sat_sig(-(longint'(t.right_speed) + longint'(t.left_speed)));
		speed_lp = sat_sig(gain_mul(err, UNITY - ctrl_reg[REG_FILTER_COEFF])
			+ gain_mul(speed_lp, ctrl_reg[REG_FILTER_COEFF]));
		travel = sat_sig(travel + scaled_mul(speed_lp, TRAVEL_SCALE, TRAVEL_SHIFT));

		pos_cmd = clip(gain_mul(sat_sig(longint'(t.position_target) - travel),
			ctrl_reg[REG_POSITION_KP]), POS_LIMIT);

		spd_err = sat_sig(pos_cmd - speed_lp);
		speed_acc = clip(speed_acc + gain_mul(spd_err, ctrl_reg[REG_SPEED_KI]), INTEG_LIMIT);
		spd_cmd = clip(gain_mul(spd_err, ctrl_reg[REG_SPEED_KP]) + speed_acc, SPEED_LIMIT);

		bal = sat_sig(sat_sig(-gain_mul(sat_sig(longint'(t.pitch_angle) - spd_cmd),
			ctrl_reg[REG_ANGLE_GAIN])) - gain_mul(longint'(t.pitch_rate), ctrl_reg[REG_RATE_GAIN]));

		heading_goal = sat_sig(heading_goal + longint'(t.turn_step));
		setp = sat_sig(TURN_ORIGIN + 2 * heading_goal);
		terr = sat_sig(setp - yaw_sum);
		turn = gain_mul(terr, ctrl_reg[REG_TURN_KP])
			+ gain_mul(sat_sig(terr - last_turn_err), ctrl_reg[REG_TURN_KD]);
		last_turn_err = terr;
		turn = clip(turn, DRIVE_LIMIT);

		r = clip(bal + turn, DRIVE_LIMIT);
		l = clip(bal - 2 * turn, DRIVE_LIMIT);
		o.right_drive = drive_t'(r);
		o.left_drive = drive_t'(l);
		return o;
	endfunction

	function automatic word_t spread(int unsigned span);
		return word_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
	endfunction

	function automatic word_t maybe_wild(word_t x);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 4))
				0: return WMAX;
				1: return WMIN;
				2: return word_t'(0);
				3: return word_t'(-1);
				default: return word_t'(1);
			endcase
		end
		if (r < 14)
			return word_t'($urandom);
		return x;
	endfunction

	function automatic tick_in_t random_tick();
		tick_in_t t;
		int unsigned r;
		r = $urandom_range(0, 99);
		yaw_walk = yaw_walk + longint'(spread(24000));
		if ($urandom_range(0, 19) == 0)
			yaw_walk = longint'(spread(205887));
		if (yaw_walk > YAW_BIAS)
			yaw_walk = yaw_walk - 2 * YAW_BIAS;
		else if (yaw_walk < -YAW_BIAS)
			yaw_walk = yaw_walk + 2 * YAW_BIAS;
		t.right_speed = spread(1310720);
		t.left_speed = spread(1310720);
		t.yaw_angle = word_t'(yaw_walk);
		t.pitch_angle = spread(32768);
		t.pitch_rate = spread(131072);
		t.position_target = spread(655360);
		t.turn_step = spread(3277);
		if (r >= 88) begin
			t.right_speed = word_t'($urandom);
			t.left_speed = word_t'($urandom);
			t.yaw_angle = word_t'($urandom);
			t.pitch_angle = word_t'($urandom);
			t.pitch_rate = word_t'($urandom);
			t.position_target = word_t'($urandom);
			t.turn_step = word_t'($urandom);
		end else if (r >= 68) begin
			t.right_speed = maybe_wild(t.right_speed);
			t.left_speed = maybe_wild(t.left_speed);
			t.yaw_angle = maybe_wild(t.yaw_angle);
			t.pitch_angle = maybe_wild(t.pitch_angle);
			t.pitch_rate = maybe_wild(t.pitch_rate);
			t.position_target = maybe_wild(t.position_target);
			t.turn_step = maybe_wild(t.turn_step);
		end
		return t;
	endfunction

	function automatic tick_in_t make_tick(word_t rs, word_t ls, word_t yaw, word_t pitch,
			word_t rate, word_t tgt, word_t step);
		tick_in_t t;
		t.right_speed = rs;
		t.left_speed = ls;
		t.yaw_angle = yaw;
		t.pitch_angle = pitch;
		t.pitch_rate = rate;
		t.position_target = tgt;
		t.turn_step = step;
		return t;
	endfunction

	function automatic int next_gap(int longest);
		int unsigned r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, longest);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == REG_FILTER_COEFF)
			ctrl_reg[idx] = longint'(data[FC_W-1:0]);
		else
			ctrl_reg[idx] = longint'($signed(data));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				drive_q.push_back(controller_tick(held_tick));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() > 0) begin
					held_tick = tick_q.pop_front();
					s_axis_tdata <= {held_tick.turn_step, held_tick.position_target,
						held_tick.pitch_rate, held_tick.pitch_angle, held_tick.yaw_angle,
						held_tick.left_speed, held_tick.right_speed};
					s_axis_tvalid <= 1'b1;
					send_gap = next_gap(40);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					$error("drive item with no tick outstanding: right_drive %0d, left_drive %0d",
						$signed(m_axis_tdata[DRIVE_W-1:0]), $signed(m_axis_tdata[OUT_W-1:DRIVE_W]));
					fail_count++;
				end else begin
					want = drive_q.pop_front();
					if (m_axis_tdata[DRIVE_W-1:0] !== want.right_drive) begin
						$error("right_drive mismatch: expected %0d, actual %0d",
							want.right_drive, $signed(m_axis_tdata[DRIVE_W-1:0]));
						fail_count++;
					end
					if (m_axis_tdata[OUT_W-1:DRIVE_W] !== want.left_drive) begin
						$error("left_drive mismatch: expected %0d, actual %0d",
							want.left_drive, $signed(m_axis_tdata[OUT_W-1:DRIVE_W]));
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = next_gap(80);
				m_axis_tready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		longint g;
		reset_reg[REG_FILTER_COEFF] = longint'(FC_RESET);
		reset_reg[REG_POSITION_KP] = longint'(PKP_RESET);
		reset_reg[REG_SPEED_KP] = longint'(SKP_RESET);
		reset_reg[REG_SPEED_KI] = longint'(SKI_RESET);
		reset_reg[REG_ANGLE_GAIN] = longint'(ANG_RESET);
		reset_reg[REG_RATE_GAIN] = longint'(RATE_RESET);
		reset_reg[REG_TURN_KP] = longint'(TKP_RESET);
		reset_reg[REG_TURN_KD] = longint'(TKD_RESET);
		ctrl_reg = reset_reg;
		last_yaw = 0;
		rev_count = 0;
		speed_lp = 0;
		travel = 0;
		speed_acc = 0;
		last_turn_err = 0;
		heading_goal = 0;
		yaw_walk = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				do
					@(negedge clk);
				while (tick_q.size() != 0 || s_axis_tvalid || drive_q.size() != 0);
				repeat (4) @(posedge clk);
				case (phase)
					1: begin
						for (int r = REG_FILTER_COEFF; r <= REG_TURN_KD; r++)
							write_reg(CFG_IDX_W'(r), $urandom);
					end
					2: begin
						write_reg(REG_FILTER_COEFF, 32'hFFFF_FFFF);
						for (int r = REG_POSITION_KP; r <= REG_TURN_KD; r++)
							write_reg(CFG_IDX_W'(r), 32'h7FFF_FFFF);
					end
					3: begin
						write_reg(REG_FILTER_COEFF, 32'h0000_0000);
						for (int r = REG_POSITION_KP; r <= REG_TURN_KD; r++)
							write_reg(CFG_IDX_W'(r), 32'h8000_0000);
					end
					4: begin
						write_reg(REG_FILTER_COEFF, CFG_DATA_W'(UNITY));
						for (int r = REG_POSITION_KP; r <= REG_TURN_KD; r++)
							write_reg(CFG_IDX_W'(r), 32'h0000_0000);
					end
					default: begin
						write_reg(REG_FILTER_COEFF, ($urandom & 32'hFE00_0000)
							| CFG_DATA_W'($urandom_range(0, UNITY)));
						for (int r = REG_POSITION_KP; r <= REG_TURN_KD; r++) begin
							g = reset_reg[r] >>> $urandom_range(0, 3);
							if ($urandom_range(0, 3) == 0)
								g = -g;
							write_reg(CFG_IDX_W'(r), CFG_DATA_W'(g));
						end
					end
				endcase
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			gaps_on = (phase != NO_GAP_PHASE);

			if (phase == 0) begin
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, 0));
				tick_q.push_back(make_tick(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
				tick_q.push_back(make_tick(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
				tick_q.push_back(make_tick(WMAX, WMAX, -205887, 0, 0, 0, 0));
				tick_q.push_back(make_tick(WMIN, WMIN, 205887, 0, 0, 0, 0));
				tick_q.push_back(make_tick(0, 0, -205887, 0, 0, 0, 0));
				tick_q.push_back(make_tick(0, 0, 205887, 0, 0, 0, 0));
				tick_q.push_back(make_tick(0, 0, -205887, 0, 0, 0, 0));
				tick_q.push_back(make_tick(65536, -65536, 0, WMAX, 0, 0, 0));
				tick_q.push_back(make_tick(-65536, 65536, 0, WMIN, 0, 0, 0));
				tick_q.push_back(make_tick(0, 0, 0, 0, WMAX, 0, 0));
				tick_q.push_back(make_tick(0, 0, 0, 0, WMIN, 0, 0));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, WMAX, 0));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, WMIN, 0));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, WMAX));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, WMAX));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, WMIN));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, WMIN));
				tick_q.push_back(make_tick(0, 0, 0, 0, 0, 0, WMIN));
				tick_q.push_back(make_tick(-1, -1, -1, -1, -1, -1, -1));
				tick_q.push_back(make_tick(1, 1, 1, 1, 1, 1, 1));
				tick_q.push_back(make_tick(0, 0, WMAX, 0, 0, 0, 0));
				tick_q.push_back(make_tick(0, 0, WMIN, 0, 0, 0, 0));
			end
			for (int k = 0; k < TICKS_PER_PHASE; k++)
				tick_q.push_back(random_tick());
		end

		do
			@(negedge clk);
		while (tick_q.size() != 0 || s_axis_tvalid || drive_q.size() != 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
